@@ rtl/core/a2i_pkg.sv @@
// Shared types and constants for the adjacency to incidence converter.
package a2i_pkg;

  localparam int ROW_WIDTH        = 32;
  localparam int MAX_VERTICES_DEF = 32;

  localparam logic [5:0] VCOUNT_RESET = 6'd32;

  localparam logic [1:0] LOOP_VALUE = 2'd2;
  localparam logic [1:0] EDGE_VALUE = 2'd1;
  localparam logic [1:0] NO_VALUE   = 2'd0;

  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit_edge;
    logic emit_sum;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic edge_hit;
    logic last_col;
    logic slot_free;
  } status_t;

  typedef struct packed {
    logic       result_kind;
    logic [9:0] edge_number;
    logic [4:0] vertex_low;
    logic [4:0] vertex_high;
    logic [1:0] incidence_value;
    logic [5:0] row_degree;
    logic [5:0] max_degree;
    logic [9:0] edge_total;
    logic       last_of_row;
    logic       matrix_done;
  } result_t;

endpackage

@@ rtl/core/a2i_if.sv @@
// Valid/ready channel interfaces for rows, results and configuration.
interface a2i_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_bits;
  modport source (output valid, output row_bits, input ready);
  modport sink   (input valid, input row_bits, output ready);
endinterface

interface a2i_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [9:0] edge_number;
  logic [4:0] vertex_low;
  logic [4:0] vertex_high;
  logic [1:0] incidence_value;
  logic [5:0] row_degree;
  logic [5:0] max_degree;
  logic [9:0] edge_total;
  logic       last_of_row;
  logic       matrix_done;
  modport source (output valid, output result_kind, output edge_number, output vertex_low,
                  output vertex_high, output incidence_value, output row_degree,
                  output max_degree, output edge_total, output last_of_row,
                  output matrix_done, input ready);
  modport sink   (input valid, input result_kind, input edge_number, input vertex_low,
                  input vertex_high, input incidence_value, input row_degree,
                  input max_degree, input edge_total, input last_of_row,
                  input matrix_done, output ready);
endinterface

interface a2i_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/adjacency_to_incidence_converter_top.sv @@
// Top level of the adjacency to incidence converter.
//
// in_ch takes one adjacency row per request, rows in order from vertex 0;
// bit j of row_bits is the entry to vertex j. out_ch returns, per row, one
// edge request for each set bit at or right of the diagonal (numbered
// row-major, incidence 2 for a loop, 1 otherwise) and then a row summary
// with degree, running maximum degree and running edge count.
// cfg_ch writes vertex_count (reset 32); write it only while idle.
//
// A row passes through three phases: the row is accepted, the column counter
// walks the row column by column, and then the summary is issued.
// The column walk yields at most one result per cycle into a single output
// register. A stalled receiver holds that register and the walk waits at the
// next set bit; the next row is taken once the summary is in the register.
// After the last configured row the running counts clear.
// Reset (rst_n low, synchronous) clears the counts and vertex_count to 32.
module adjacency_to_incidence_converter_top #(
  parameter int MAX_VERTICES = a2i_pkg::MAX_VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  a2i_in_if.sink     in_ch,
  a2i_out_if.source  out_ch,
  a2i_cfg_if.sink    cfg_ch
);

  a2i_pkg::cmd_t     cmd;
  a2i_pkg::status_t  status;
  a2i_pkg::result_t  res;

  assign cfg_ch.ready = 1'b1;

  a2i_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  a2i_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_row_bits (in_ch.row_bits),
    .cfg_write   (cfg_ch.valid),
    .cfg_data    (cfg_ch.data),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_res     (res),
    .cmd         (cmd),
    .status      (status)
  );

  assign out_ch.result_kind     = res.result_kind;
  assign out_ch.edge_number     = res.edge_number;
  assign out_ch.vertex_low      = res.vertex_low;
  assign out_ch.vertex_high     = res.vertex_high;
  assign out_ch.incidence_value = res.incidence_value;
  assign out_ch.row_degree      = res.row_degree;
  assign out_ch.max_degree      = res.max_degree;
  assign out_ch.edge_total      = res.edge_total;
  assign out_ch.last_of_row     = res.last_of_row;
  assign out_ch.matrix_done     = res.matrix_done;

endmodule

@@ rtl/core/a2i_ctrl.sv @@
// Row sequencer: accepts a row, walks its columns, then issues the summary.
module a2i_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  a2i_pkg::status_t  status,
  output a2i_pkg::cmd_t     cmd
);

  a2i_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= a2i_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      a2i_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = a2i_pkg::ST_SCAN;
      end
      a2i_pkg::ST_SCAN: begin
        if ((!status.edge_hit || status.slot_free) && status.last_col)
          state_nxt = a2i_pkg::ST_SUM;
      end
      a2i_pkg::ST_SUM: begin
        if (status.slot_free) state_nxt = a2i_pkg::ST_IDLE;
      end
      default: state_nxt = a2i_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      a2i_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      a2i_pkg::ST_SCAN: begin
        // hold the column while an edge waits for the output slot
        cmd.step      = !status.edge_hit || status.slot_free;
        cmd.emit_edge = status.edge_hit && status.slot_free;
      end
      a2i_pkg::ST_SUM: begin
        cmd.emit_sum = status.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/a2i_datapath.sv @@
// Row register, column counter, running graph state and output register.
module a2i_datapath #(
  parameter int MAX_VERTICES = a2i_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       in_row_bits,
  input  logic              cfg_write,
  input  logic [5:0]        cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output a2i_pkg::result_t  out_res,
  input  a2i_pkg::cmd_t     cmd,
  output a2i_pkg::status_t  status
);

  localparam int LIM = (MAX_VERTICES < a2i_pkg::ROW_WIDTH) ? MAX_VERTICES
                                                            : a2i_pkg::ROW_WIDTH;
  localparam logic [5:0] LIM_V = 6'(LIM);

  logic [5:0]        vcount_r;
  logic [31:0]       row_bits_r;
  logic [4:0]        col_r;
  logic [5:0]        deg_r;
  logic [4:0]        row_r;
  logic [9:0]        edges_r;
  logic [5:0]        dmax_r;
  logic              out_valid_r;
  a2i_pkg::result_t  res_r;

  logic [5:0]        n_act;
  logic              bit_set;
  logic [5:0]        max_nxt;
  logic              done;

  always_comb begin
    if (vcount_r == 6'd0)      n_act = 6'd1;
    else if (vcount_r > LIM_V) n_act = LIM_V;
    else                       n_act = vcount_r;
  end

  assign bit_set          = row_bits_r[col_r];
  assign status.edge_hit  = bit_set && (col_r >= row_r);
  assign status.last_col  = ({1'b0, col_r} == (n_act - 6'd1));
  assign status.slot_free = !out_valid_r || out_ready;

  assign max_nxt = (deg_r > dmax_r) ? deg_r : dmax_r;
  assign done    = ({1'b0, row_r} + 6'd1) >= n_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= a2i_pkg::VCOUNT_RESET;
    end else if (cfg_write) begin
      vcount_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_bits_r <= in_row_bits;
      col_r      <= 5'd0;
      deg_r      <= 6'd0;
    end else if (cmd.step) begin
      col_r <= col_r + 5'd1;
      deg_r <= deg_r + {5'd0, bit_set};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= 5'd0;
      edges_r <= 10'd0;
      dmax_r  <= 6'd0;
    end else if (cmd.emit_edge) begin
      edges_r <= edges_r + 10'd1;
    end else if (cmd.emit_sum) begin
      if (done) begin
        row_r   <= 5'd0;
        edges_r <= 10'd0;
        dmax_r  <= 6'd0;
      end else begin
        row_r  <= row_r + 5'd1;
        dmax_r <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_edge || cmd.emit_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_edge) begin
      res_r.result_kind     <= a2i_pkg::KIND_EDGE;
      res_r.edge_number     <= edges_r;
      res_r.vertex_low      <= row_r;
      res_r.vertex_high     <= col_r;
      res_r.incidence_value <= (col_r == row_r) ? a2i_pkg::LOOP_VALUE
                                                : a2i_pkg::EDGE_VALUE;
      res_r.row_degree      <= 6'd0;
      res_r.max_degree      <= 6'd0;
      res_r.edge_total      <= 10'd0;
      res_r.last_of_row     <= 1'b0;
      res_r.matrix_done     <= 1'b0;
    end else if (cmd.emit_sum) begin
      res_r.result_kind     <= a2i_pkg::KIND_SUMMARY;
      res_r.edge_number     <= 10'd0;
      res_r.vertex_low      <= row_r;
      res_r.vertex_high     <= 5'd0;
      res_r.incidence_value <= a2i_pkg::NO_VALUE;
      res_r.row_degree      <= deg_r;
      res_r.max_degree      <= max_nxt;
      res_r.edge_total      <= edges_r;
      res_r.last_of_row     <= 1'b1;
      res_r.matrix_done     <= done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

@@ rtl/core/a2i_checker.sv @@
// Port-level checks for the converter, bound to the top level.
module a2i_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic [9:0] edge_number,
  input logic [4:0] vertex_low,
  input logic [4:0] vertex_high,
  input logic [1:0] incidence_value,
  input logic       last_of_row,
  input logic       matrix_done
);

  // a stalled result stays valid and keeps its kind, edge number and vertices
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(edge_number) &&
      $stable(vertex_low) && $stable(vertex_high) && $stable(result_kind))
    else $error("stalled result changed");

  // one row at a time: in_ready is low right after a row is taken
  a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("row accepted while previous row in progress");

  a_edge_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == a2i_pkg::KIND_EDGE) |->
      !last_of_row && !matrix_done && (vertex_high >= vertex_low) &&
      ((incidence_value == a2i_pkg::LOOP_VALUE) == (vertex_high == vertex_low)) &&
      (incidence_value != a2i_pkg::NO_VALUE))
    else $error("malformed edge result");

  a_sum_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == a2i_pkg::KIND_SUMMARY) |->
      last_of_row && (incidence_value == a2i_pkg::NO_VALUE) && (edge_number == 10'd0))
    else $error("malformed row summary");

endmodule

bind adjacency_to_incidence_converter_top a2i_checker u_a2i_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .result_kind     (out_ch.result_kind),
  .edge_number     (out_ch.edge_number),
  .vertex_low      (out_ch.vertex_low),
  .vertex_high     (out_ch.vertex_high),
  .incidence_value (out_ch.incidence_value),
  .last_of_row     (out_ch.last_of_row),
  .matrix_done     (out_ch.matrix_done)
);

@@ tb/sv/tb_adjacency_to_incidence_converter_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the adjacency to incidence converter top level.
module tb_adjacency_to_incidence_converter_top;

  localparam int ROW_LIMIT    = (a2i_pkg::MAX_VERTICES_DEF < a2i_pkg::ROW_WIDTH)
                                ? a2i_pkg::MAX_VERTICES_DEF : a2i_pkg::ROW_WIDTH;
  localparam int MAX_IDLE     = 16;
  localparam int SETTLE       = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ROWS  = 330;
  localparam int NUM_DIRECTED = 21;

  typedef enum bit {OP_ROW, OP_CFG} step_op_t;

  // summary fields typed into the table; checked in place of the prediction
  typedef struct packed {
    bit         typed;
    logic [5:0] degree;
    logic [5:0] peak;
    logic [9:0] total;
    logic       done;
  } summary_t;

  typedef struct packed {
    step_op_t    op;
    logic [31:0] value;
    summary_t    summary;
  } step_t;

  localparam summary_t UNTYPED = '0;

  logic clk;
  logic rst_n;

  a2i_in_if  in_ch ();
  a2i_out_if out_ch ();
  a2i_cfg_if cfg_ch ();

  adjacency_to_incidence_converter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic [5:0] vertex_setting = a2i_pkg::VCOUNT_RESET;
  logic [4:0] row_pos        = '0;
  logic [9:0] edge_count     = '0;
  logic [5:0] peak_degree    = '0;

  a2i_pkg::result_t expected_results [$];
  summary_t         typed_summaries [$];
  int               mismatches = 0;
  int               max_idle   = MAX_IDLE;
  int               quiet_cycles = 0;

  step_t directed_steps [NUM_DIRECTED] = '{
    '{OP_ROW, 32'hFFFF_FFFF, '{1'b1, 6'd32, 6'd32, 10'd32, 1'b0}},
    '{OP_CFG, 32'd0,         UNTYPED},
    '{OP_ROW, 32'h0000_0001, '{1'b1, 6'd1, 6'd32, 10'd32, 1'b1}},
    '{OP_ROW, 32'hFFFF_FFFE, '{1'b1, 6'd0, 6'd0, 10'd0, 1'b1}},
    '{OP_ROW, 32'h0000_0001, '{1'b1, 6'd1, 6'd1, 10'd1, 1'b1}},
    '{OP_CFG, 32'd2,         UNTYPED},
    '{OP_ROW, 32'h0000_0003, '{1'b1, 6'd2, 6'd2, 10'd2, 1'b0}},
    '{OP_ROW, 32'h0000_0001, '{1'b1, 6'd1, 6'd2, 10'd2, 1'b1}},
    '{OP_CFG, 32'd63,        UNTYPED},
    '{OP_ROW, 32'h8000_0000, '{1'b1, 6'd1, 6'd1, 10'd1, 1'b0}},
    '{OP_ROW, 32'h0000_0000, '{1'b1, 6'd0, 6'd1, 10'd1, 1'b0}},
    '{OP_ROW, 32'hAAAA_AAAA, UNTYPED},
    '{OP_ROW, 32'h5555_5555, UNTYPED},
    '{OP_CFG, 32'd3,         UNTYPED},
    '{OP_ROW, 32'h7FFF_FFFF, UNTYPED},
    '{OP_CFG, 32'd33,        UNTYPED},
    '{OP_ROW, 32'hFFFF_FFFF, '{1'b1, 6'd32, 6'd32, 10'd32, 1'b0}},
    '{OP_CFG, 32'd1,         UNTYPED},
    '{OP_ROW, 32'h0000_0000, '{1'b1, 6'd0, 6'd32, 10'd32, 1'b1}},
    '{OP_CFG, 32'd32,        UNTYPED},
    '{OP_ROW, 32'h0000_0000, '{1'b1, 6'd0, 6'd0, 10'd0, 1'b0}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int active_count(input logic [5:0] setting);
    int n;
    n = int'(setting);
    if (n == 0) n = 1;
    if (n > ROW_LIMIT) n = ROW_LIMIT;
    return n;
  endfunction

  // Expand one adjacency row into its edge columns and the row summary.
  function automatic void convert_row(input logic [31:0] row_in);
    int               n;
    logic [31:0]      live;
    logic [5:0]       degree;
    bit               closes;
    a2i_pkg::result_t r;
    n = active_count(vertex_setting);
    live = (n >= 32) ? row_in : (row_in & ((32'd1 << n) - 32'd1));
    degree = 6'($countones(live));
    for (int j = int'(row_pos); j < n; j++) begin
      if (live[j]) begin
        r = '0;
        r.result_kind     = a2i_pkg::KIND_EDGE;
        r.edge_number     = edge_count;
        r.vertex_low      = row_pos;
        r.vertex_high     = 5'(j);
        r.incidence_value = (j == int'(row_pos)) ? a2i_pkg::LOOP_VALUE : a2i_pkg::EDGE_VALUE;
        expected_results.push_back(r);
        edge_count = edge_count + 10'd1;
      end
    end
    if (degree > peak_degree) peak_degree = degree;
    closes = (int'(row_pos) + 1 >= n);
    r = '0;
    r.result_kind     = a2i_pkg::KIND_SUMMARY;
    r.vertex_low      = row_pos;
    r.incidence_value = a2i_pkg::NO_VALUE;
    r.row_degree      = degree;
    r.max_degree      = peak_degree;
    r.edge_total      = edge_count;
    r.last_of_row     = 1'b1;
    r.matrix_done     = closes;
    expected_results.push_back(r);
    if (closes) begin
      row_pos     = '0;
      edge_count  = '0;
      peak_degree = '0;
    end else begin
      row_pos = row_pos + 5'd1;
    end
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result(input a2i_pkg::result_t got, input a2i_pkg::result_t want);
    if (got.result_kind !== want.result_kind)
      note_mismatch("result_kind", int'(got.result_kind), int'(want.result_kind));
    if (got.edge_number !== want.edge_number)
      note_mismatch("edge_number", int'(got.edge_number), int'(want.edge_number));
    if (got.vertex_low !== want.vertex_low)
      note_mismatch("vertex_low", int'(got.vertex_low), int'(want.vertex_low));
    if (got.vertex_high !== want.vertex_high)
      note_mismatch("vertex_high", int'(got.vertex_high), int'(want.vertex_high));
    if (got.incidence_value !== want.incidence_value)
      note_mismatch("incidence_value", int'(got.incidence_value), int'(want.incidence_value));
    if (got.row_degree !== want.row_degree)
      note_mismatch("row_degree", int'(got.row_degree), int'(want.row_degree));
    if (got.max_degree !== want.max_degree)
      note_mismatch("max_degree", int'(got.max_degree), int'(want.max_degree));
    if (got.edge_total !== want.edge_total)
      note_mismatch("edge_total", int'(got.edge_total), int'(want.edge_total));
    if (got.last_of_row !== want.last_of_row)
      note_mismatch("last_of_row", int'(got.last_of_row), int'(want.last_of_row));
    if (got.matrix_done !== want.matrix_done)
      note_mismatch("matrix_done", int'(got.matrix_done), int'(want.matrix_done));
  endtask

  // Track accepted requests on all three channels and watch for a hang.
  always @(posedge clk) begin
    a2i_pkg::result_t got;
    a2i_pkg::result_t want;
    summary_t         tag;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) vertex_setting = cfg_ch.data;
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind     = out_ch.result_kind;
        got.edge_number     = out_ch.edge_number;
        got.vertex_low      = out_ch.vertex_low;
        got.vertex_high     = out_ch.vertex_high;
        got.incidence_value = out_ch.incidence_value;
        got.row_degree      = out_ch.row_degree;
        got.max_degree      = out_ch.max_degree;
        got.edge_total      = out_ch.edge_total;
        got.last_of_row     = out_ch.last_of_row;
        got.matrix_done     = out_ch.matrix_done;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result, edge_number", int'(got.edge_number), -1);
        end else begin
          want = expected_results.pop_front();
          check_result(got, want);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        tag = typed_summaries.pop_front();
        convert_row(in_ch.row_bits);
        if (tag.typed) begin
          want = expected_results.pop_back();
          want.row_degree  = tag.degree;
          want.max_degree  = tag.peak;
          want.edge_total  = tag.total;
          want.matrix_done = tag.done;
          expected_results.push_back(want);
        end
      end
      if ((cfg_ch.valid && cfg_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (in_ch.valid && in_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[%0t] no request accepted for %0d cycles", $time, STALL_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Result side: stall a random number of cycles before each result.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, max_idle);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_row(input logic [31:0] row_in, input summary_t tag);
    int gap;
    gap = $urandom_range(0, max_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_summaries.push_back(tag);
    in_ch.valid    <= 1'b1;
    in_ch.row_bits <= row_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop the row request and hold until every expected result is back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [5:0] setting);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= setting;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] adj [32];
    logic [31:0] mask;
    logic [31:0] row_in;
    logic [5:0]  setting;
    int          rows_done;
    int          n;
    int          start;
    int          rows;
    int          style;
    int          density;
    int          idx;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.row_bits <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].op == OP_CFG) write_vertex_count(directed_steps[i].value[5:0]);
      else send_row(directed_steps[i].value, directed_steps[i].summary);
    end

    rows_done = 0;
    while (rows_done < RANDOM_ROWS) begin
      case ($urandom_range(0, 9))
        0:       setting = 6'd0;
        1:       setting = 6'($urandom_range(33, 63));
        2:       setting = 6'd32;
        default: setting = 6'($urandom_range(1, 8));
      endcase
      write_vertex_count(setting);
      // idle both sides at random, except in a calm stretch now and then
      max_idle = ($urandom_range(0, 4) == 0) ? 0 : MAX_IDLE;
      n = active_count(setting);
      mask = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
      start = int'(row_pos);

      case ($urandom_range(0, 5))
        0:       density = 0;
        1:       density = 100;
        default: density = $urandom_range(5, 95);
      endcase
      foreach (adj[i]) adj[i] = '0;
      for (int i = 0; i < n; i++) begin
        for (int j = i; j < n; j++) begin
          if ($urandom_range(0, 99) < density) begin
            adj[i][j] = 1'b1;
            adj[j][i] = 1'b1;
          end
        end
      end

      style = $urandom_range(0, 9);
      rows = (start >= n) ? 1 : n - start;
      // break the matrix off early; the next write then lands mid-matrix
      if (style == 9 && rows > 1) rows = $urandom_range(1, rows - 1);

      for (int k = 0; k < rows; k++) begin
        idx = start + k;
        if (style == 7 || style == 8 || idx >= n) row_in = $urandom;
        else row_in = adj[idx];
        if ($urandom_range(0, 3) == 0) row_in = row_in | ($urandom & ~mask);
        send_row(row_in, UNTYPED);
      end
      rows_done += rows;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
